// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle.
`define CT_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("ctlut assertion failed");

// Check an implication in the next cycle.
`define CT_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("ctlut assertion failed");

`endif

// ----- hdl/ctlut_pkg.sv -----
`default_nettype none
package ctlut_pkg;
	localparam int AXIS_CELLS_DEF = 64;
	localparam int CMAX_W = 6;
	localparam int BND_W = 7;
	localparam int IN_W = 48;
	localparam int OUT_W = 8;
	localparam logic [7:0] MULTI_FLAG = 8'h80;
	localparam logic [7:0] MASK_BITS = 8'h7f;

	typedef enum logic [1:0] {
		OP_CLASSIFY = 2'd0,
		OP_ADD      = 2'd1,
		OP_REPLACE  = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CLASS,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		logic              empty;
		logic [CMAX_W-1:0] lo_y;
		logic [CMAX_W-1:0] lo_u;
		logic [CMAX_W-1:0] lo_v;
		logic [BND_W-1:0]  hi_y;
		logic [BND_W-1:0]  hi_u;
		logic [BND_W-1:0]  hi_v;
		logic [2:0]        add_class;
		logic [2:0]        from_class;
		logic [7:0]        to_class;
	} job_t;

	function automatic logic [7:0] class_bit(input logic [7:0] k);
		logic [7:0] r;
		r = 8'd0;
		if (k >= 8'd1 && k <= 8'd7) begin
			r = 8'd1 << (k[2:0] - 3'd1);
		end
		return r;
	endfunction

	function automatic logic [7:0] merge_add(input logic [7:0] c, input logic [2:0] k);
		logic [7:0] k8;
		logic [7:0] r;
		k8 = {5'd0, k};
		r = c;
		if ((c & MULTI_FLAG) != 8'd0 && k8 != 8'd0) begin
			r = c | class_bit(k8);
		end else if (c == 8'd0 || k8 == 8'd0) begin
			r = k8;
		end else if (c != k8) begin
			r = class_bit(c) | class_bit(k8) | MULTI_FLAG;
		end
		return r;
	endfunction

	function automatic logic [7:0] merge_replace(input logic [7:0] c,
			input logic [2:0] from, input logic [7:0] to);
		logic [7:0] f8;
		logic [7:0] m;
		logic [7:0] r;
		f8 = {5'd0, from};
		m = c;
		r = c;
		if (c == f8) begin
			r = to;
		end else if (f8 != 8'd0 && (c & MULTI_FLAG) != 8'd0
				&& (c & class_bit(f8)) != 8'd0) begin
			m = c & ~class_bit(f8);
			if ((to & MULTI_FLAG) != 8'd0) begin
				m = m | to;
			end else if (to != 8'd0) begin
				m = m | class_bit(to);
			end
			r = m;
			for (int i = 0; i < 7; i++) begin
				if ((m & MASK_BITS) == (8'd1 << i)) begin
					r = 8'(i + 1);
				end
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/ctlut_ram.sv -----
`default_nettype none
module ctlut_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ctlut_front.sv -----
`default_nettype none
module ctlut_front #(
	parameter int AXIS_CELLS = ctlut_pkg::AXIS_CELLS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       hold,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [ctlut_pkg::IN_W-1:0] s_tdata,
	output logic                            job_valid,
	input  wire logic                       job_ready,
	output ctlut_pkg::job_t                 job
);
	localparam logic [7:0] NCELLS = 8'(AXIS_CELLS);

	logic            valid_s1;
	ctlut_pkg::job_t job_s1;
	ctlut_pkg::job_t job_d;
	logic [6:0]      size;
	logic [5:0]      half;
	logic [5:0]      c_y, c_u, c_v;
	logic [5:0]      l_y, l_u, l_v;

	function automatic logic [5:0] coord(input logic [7:0] v);
		logic [15:0] p;
		p = 16'({8'd0, v} * 16'(AXIS_CELLS));
		return p[13:8];
	endfunction

	function automatic logic [5:0] low_of(input logic [5:0] c, input logic [5:0] h);
		return (c >= h) ? c - h : 6'd0;
	endfunction

	function automatic logic [6:0] high_of(input logic [5:0] l, input logic [6:0] s);
		logic [7:0] sum;
		sum = {2'd0, l} + {1'b0, s};
		return (sum > NCELLS) ? NCELLS[6:0] : sum[6:0];
	endfunction

	assign size = s_tdata[46:40];
	assign half = size[6:1];
	assign c_y = coord(s_tdata[9:2]);
	assign c_u = coord(s_tdata[17:10]);
	assign c_v = coord(s_tdata[25:18]);
	assign l_y = low_of(c_y, half);
	assign l_u = low_of(c_u, half);
	assign l_v = low_of(c_v, half);

	always_comb begin
		job_d.op = ctlut_pkg::op_t'(s_tdata[1:0]);
		job_d.empty = (size == 7'd0);
		job_d.add_class = s_tdata[28:26];
		job_d.from_class = s_tdata[31:29];
		job_d.to_class = s_tdata[39:32];
		if (job_d.op == ctlut_pkg::OP_CLASSIFY) begin
			job_d.lo_y = c_y;
			job_d.lo_u = c_u;
			job_d.lo_v = c_v;
		end else begin
			job_d.lo_y = l_y;
			job_d.lo_u = l_u;
			job_d.lo_v = l_v;
		end
		job_d.hi_y = high_of(l_y, size);
		job_d.hi_u = high_of(l_u, size);
		job_d.hi_v = high_of(l_v, size);
	end

	assign s_tready = !hold && (!valid_s1 || job_ready);
	assign job_valid = valid_s1;
	assign job = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			job_s1 <= job_d;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ctlut_queue.sv -----
`default_nettype none
module ctlut_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ctlut_pkg::job_t in_job,
	output logic                 out_valid,
	input  wire logic            out_pop,
	output ctlut_pkg::job_t      out_job
);
	ctlut_pkg::job_t slots_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      count_q;
	logic            push;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_job = slots_q[rd_q];
	assign push = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (out_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, out_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= in_job;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ctlut_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module ctlut_back #(
	parameter int AXIS_CELLS = ctlut_pkg::AXIS_CELLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	output logic                             clearing,
	input  wire logic                        job_valid,
	output logic                             job_pop,
	input  wire ctlut_pkg::job_t             job,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [ctlut_pkg::OUT_W-1:0]      m_tdata
);
	localparam int CW = $clog2(AXIS_CELLS);
	localparam int AW = 3 * CW;
	localparam int DEPTH = 1 << AW;

	ctlut_pkg::state_t state_q, state_d;
	ctlut_pkg::job_t   job_q;
	logic [AW-1:0]     clr_q;
	logic [5:0]        y_q, u_q, v_q;
	logic [7:0]        res_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              we, re;
	logic [AW-1:0]     waddr, raddr, cur_addr;
	logic [7:0]        wdata, rdata;
	logic              last_v, last_u, last_y;
	logic              take;
	logic              load_out;

	assign cur_addr = {y_q[CW-1:0], u_q[CW-1:0], v_q[CW-1:0]};
	assign last_v = ({1'b0, v_q} + 7'd1) == job_q.hi_v;
	assign last_u = ({1'b0, u_q} + 7'd1) == job_q.hi_u;
	assign last_y = ({1'b0, y_q} + 7'd1) == job_q.hi_y;
	assign clearing = (state_q == ctlut_pkg::ST_CLEAR);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	ctlut_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata_q(rdata)
	);

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		take = 1'b0;
		load_out = 1'b0;
		we = 1'b0;
		re = 1'b0;
		waddr = cur_addr;
		raddr = cur_addr;
		wdata = 8'd0;
		unique case (state_q)
			ctlut_pkg::ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ctlut_pkg::ST_IDLE;
				end
			end
			ctlut_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					take = 1'b1;
					if (job.op == ctlut_pkg::OP_CLASSIFY) begin
						re = 1'b1;
						raddr = {job.lo_y[CW-1:0], job.lo_u[CW-1:0], job.lo_v[CW-1:0]};
						state_d = ctlut_pkg::ST_CLASS;
					end else if (job.op == ctlut_pkg::OP_NOP || job.empty) begin
						state_d = ctlut_pkg::ST_DONE;
					end else begin
						state_d = ctlut_pkg::ST_READ;
					end
				end
			end
			ctlut_pkg::ST_CLASS: begin
				state_d = ctlut_pkg::ST_DONE;
			end
			ctlut_pkg::ST_READ: begin
				re = 1'b1;
				state_d = ctlut_pkg::ST_WRITE;
			end
			ctlut_pkg::ST_WRITE: begin
				we = 1'b1;
				if (job_q.op == ctlut_pkg::OP_ADD) begin
					wdata = ctlut_pkg::merge_add(rdata, job_q.add_class);
				end else begin
					wdata = ctlut_pkg::merge_replace(rdata, job_q.from_class, job_q.to_class);
				end
				state_d = (last_v && last_u && last_y) ? ctlut_pkg::ST_DONE
					: ctlut_pkg::ST_READ;
			end
			ctlut_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d = ctlut_pkg::ST_IDLE;
				end
			end
			default: state_d = ctlut_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctlut_pkg::ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ctlut_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job;
			y_q <= job.lo_y;
			u_q <= job.lo_u;
			v_q <= job.lo_v;
			res_q <= 8'd0;
		end
		if (state_q == ctlut_pkg::ST_CLASS) begin
			res_q <= rdata;
		end
		if (state_q == ctlut_pkg::ST_WRITE) begin
			if (!last_v) begin
				v_q <= v_q + 6'd1;
			end else begin
				v_q <= job_q.lo_v;
				if (!last_u) begin
					u_q <= u_q + 6'd1;
				end else begin
					u_q <= job_q.lo_u;
					y_q <= y_q + 6'd1;
				end
			end
		end
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	`CT_ASSERT_IMP(a_pop_idle, job_pop, state_q == ctlut_pkg::ST_IDLE && job_valid)
	`CT_ASSERT_IMP(a_write_phase, we, state_q == ctlut_pkg::ST_CLEAR || state_q == ctlut_pkg::ST_WRITE)
	`CT_ASSERT_NEXT(a_done_idle, load_out, state_q == ctlut_pkg::ST_IDLE && m_tvalid)
endmodule
`default_nettype wire

// ----- hdl/color_table_classify_and_edit.sv -----
`default_nettype none
// Color class lookup table of AXIS_CELLS^3 cells, with cube add and replace edits.
// After reset the table is swept to zero one cell per cycle over all 2^(3*clog2(AXIS_CELLS))
// cells (262144 at 64 cells per axis); no item is taken during that pass. Items then go
// through a two-entry queue to a single-port-pair table engine that works on one item at
// a time: a classify reads its cell and loads the byte into the result register; an edit
// reads each cell of its cube, then writes the merged byte, since every cell is a
// read-modify-write through the table RAM's registered read. Each item gives one result.
module color_table_classify_and_edit #(
	parameter int AXIS_CELLS = ctlut_pkg::AXIS_CELLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// func, luma, blue_diff, red_diff, add_class, from_class, to_class, cube_size
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// class_out
	output logic [7:0]       m_tdata
);
	logic            clearing;
	logic            f_valid, f_ready;
	ctlut_pkg::job_t f_job;
	logic            q_valid, q_pop;
	ctlut_pkg::job_t q_job;

	ctlut_front #(.AXIS_CELLS(AXIS_CELLS)) u_front (
		.clk(clk), .arst_n(arst_n), .hold(clearing),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	ctlut_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
		.out_valid(q_valid), .out_pop(q_pop), .out_job(q_job)
	);

	ctlut_back #(.AXIS_CELLS(AXIS_CELLS)) u_back (
		.clk(clk), .arst_n(arst_n), .clearing(clearing),
		.job_valid(q_valid), .job_pop(q_pop), .job(q_job),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule
`default_nettype wire
